// File: src/atrm_pkg.sv
// ----------------------------------------------------------------------------
// atrm_pkg
// shared types and constants for the adaptive threshold region merge block
// ----------------------------------------------------------------------------
package atrm_pkg;

    localparam int MAX_PIXELS_DEF = 65536;
    localparam int IDX_W          = 16;
    localparam int WEIGHT_W       = 15;
    localparam int SIZE_W         = 17;
    localparam int K_W            = 22;
    localparam int PROD_W         = WEIGHT_W + SIZE_W;

    localparam logic [K_W-1:0]    K_RESET  = K_W'(19200);
    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

    typedef struct packed {
        logic [IDX_W-1:0]    edge_start;
        logic [IDX_W-1:0]    edge_end;
        logic [WEIGHT_W-1:0] edge_weight;
    } edge_req_t;

    typedef struct packed {
        logic                merged;
        logic [IDX_W-1:0]    result_root;
        logic [SIZE_W-1:0]   result_size;
    } merge_res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

// File: src/atrm_store.sv
// ----------------------------------------------------------------------------
// atrm_store
// pixel store: parent link, component size and internal weight per pixel,
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module atrm_store
    import atrm_pkg::*;
#(
    parameter int DEPTH = MAX_PIXELS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  store_ctl_t          ctl,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       wr_parent,
    input  logic [SIZE_W-1:0]   wr_size,
    input  logic [WEIGHT_W-1:0] wr_weight,
    output logic [AW-1:0]       rd_parent,
    output logic [SIZE_W-1:0]   rd_size,
    output logic [WEIGHT_W-1:0] rd_weight
);

    localparam int ENT_W = AW + SIZE_W + WEIGHT_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= {wr_parent, wr_size, wr_weight};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_parent = rd_data_reg[ENT_W-1 -: AW];
    assign rd_size   = rd_data_reg[WEIGHT_W +: SIZE_W];
    assign rd_weight = rd_data_reg[WEIGHT_W-1:0];

endmodule

// File: src/atrm_limit.sv
// ----------------------------------------------------------------------------
// atrm_limit
// threshold test w <= internal + floor(k / size), done as
// (w - internal) * size <= k, two register stages
// ----------------------------------------------------------------------------
module atrm_limit
    import atrm_pkg::*;
(
    input  logic                clk,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [WEIGHT_W-1:0] internal,
    input  logic [SIZE_W-1:0]   size,
    input  logic [K_W-1:0]      k_scaled,
    output logic                ok
);

    logic [WEIGHT_W-1:0] diff;
    logic [PROD_W-1:0]   prod_reg;
    logic                le_reg;
    logic                ok_reg;

    assign diff = weight - internal;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(diff) * PROD_W'(size);
        le_reg   <= (weight <= internal);
        ok_reg   <= le_reg || (prod_reg <= PROD_W'(k_scaled));
    end

    assign ok = ok_reg;

endmodule

// File: src/adaptive_threshold_region_merge.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_region_merge
// union-find merge step of graph segmentation with adaptive thresholds
// ----------------------------------------------------------------------------
// Edges come in on in_data (in_valid / in_stall), sorted by weight. Each
// request gives exactly one result on out_data (out_valid / out_stall):
// merged flag, root of the resulting component and its pixel count.
// Per-pixel state sits in one single-port-read memory. Each request walks
// both parent chains, a read state and a check state per memory step, runs the two threshold
// tests through one multiplier, and writes back two entries on a merge.
// The walk grows with the chain depths (at most log2 of the pixel count);
// edges with an end out of range or with both ends in one component
// skip the later steps. One request is worked on at a time; a finished
// result waits in the output register while the next request is accepted.
// After reset the memory is swept one entry per cycle, all MAX_PIXELS entries,
// with in_stall high; k_scaled resets to 300.0 and may be written through
// cfg_wr_en / cfg_wr_data whenever the block is idle. A stalled output
// holds its result and the block waits before delivering the next one.
// ----------------------------------------------------------------------------
module adaptive_threshold_region_merge
    import atrm_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [K_W-1:0] cfg_wr_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  edge_req_t      in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output merge_res_t     out_data
);

    localparam int AW = $clog2(MAX_PIXELS);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_RD_A     = 13'b0000000000100,
        S_CHK_A    = 13'b0000000001000,
        S_RD_B     = 13'b0000000010000,
        S_CHK_B    = 13'b0000000100000,
        S_LIM_A    = 13'b0000001000000,
        S_LIM_B    = 13'b0000010000000,
        S_LIM_C    = 13'b0000100000000,
        S_DECIDE   = 13'b0001000000000,
        S_WR_CHILD = 13'b0010000000000,
        S_WR_ROOT  = 13'b0100000000000,
        S_FINISH   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [K_W-1:0]      k_reg;
    edge_req_t           req_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       a_reg, b_reg;
    logic [SIZE_W-1:0]   sa_reg, sb_reg;
    logic [WEIGHT_W-1:0] ia_reg, ib_reg;
    logic                ok_a_reg;
    logic [AW-1:0]       nr_reg, child_reg;
    logic [SIZE_W-1:0]   sum_reg, child_size_reg;
    logic [WEIGHT_W-1:0] m_reg, child_wt_reg;
    logic                res_merged_reg;
    logic [IDX_W-1:0]    res_root_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic                out_valid_reg;
    merge_res_t          out_data_reg;

    store_ctl_t          st_ctl;
    logic [AW-1:0]       st_wr_addr, st_wr_parent;
    logic [SIZE_W-1:0]   st_wr_size;
    logic [WEIGHT_W-1:0] st_wr_weight;
    logic [AW-1:0]       rd_parent;
    logic [SIZE_W-1:0]   rd_size;
    logic [WEIGHT_W-1:0] rd_weight;

    logic [WEIGHT_W-1:0] lim_internal;
    logic [SIZE_W-1:0]   lim_size;
    logic                lim_ok;

    logic                accept;
    logic                out_free;
    logic                s_in_range, e_in_range;
    logic [AW+15:0]      s_wide, e_wide;
    logic [AW+15:0]      nr_wide;
    logic [AW-1:0]       s_idx, e_idx;
    logic                merge_ok;
    logic                b_wins;
    logic [SIZE_W:0]     sum_raw;
    logic [SIZE_W-1:0]   sum_sat;
    logic [WEIGHT_W-1:0] m_ab, m_all;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign s_wide     = {{AW{1'b0}}, in_data.edge_start};
    assign e_wide     = {{AW{1'b0}}, req_reg.edge_end};
    assign s_idx      = s_wide[AW-1:0];
    assign e_idx      = e_wide[AW-1:0];
    assign s_in_range = 32'(req_reg.edge_start) < 32'(MAX_PIXELS);
    assign e_in_range = 32'(req_reg.edge_end) < 32'(MAX_PIXELS);
    assign nr_wide    = {16'b0, nr_reg};

    assign merge_ok = ok_a_reg && lim_ok;
    assign b_wins   = sb_reg > sa_reg;
    assign sum_raw  = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign sum_sat  = sum_raw[SIZE_W] ? SIZE_SAT : sum_raw[SIZE_W-1:0];
    assign m_ab     = (ia_reg > ib_reg) ? ia_reg : ib_reg;
    assign m_all    = (m_ab > req_reg.edge_weight) ? m_ab : req_reg.edge_weight;

    assign lim_internal = (state_reg == S_LIM_B) ? ib_reg : ia_reg;
    assign lim_size     = (state_reg == S_LIM_B) ? sb_reg : sa_reg;

    atrm_limit u_limit (
        .clk      (clk),
        .weight   (req_reg.edge_weight),
        .internal (lim_internal),
        .size     (lim_size),
        .k_scaled (k_reg),
        .ok       (lim_ok)
    );

    always_comb
    begin
        st_ctl.rd_en = (state_reg == S_RD_A) || (state_reg == S_RD_B);
        st_ctl.wr_en = (state_reg == S_CLEAR) || (state_reg == S_WR_CHILD)
                    || (state_reg == S_WR_ROOT);
        st_wr_addr   = clr_cnt_reg;
        st_wr_parent = clr_cnt_reg;
        st_wr_size   = SIZE_ONE;
        st_wr_weight = '0;
        if (state_reg == S_WR_CHILD)
        begin
            st_wr_addr   = child_reg;
            st_wr_parent = nr_reg;
            st_wr_size   = child_size_reg;
            st_wr_weight = child_wt_reg;
        end
        else if (state_reg == S_WR_ROOT)
        begin
            st_wr_addr   = nr_reg;
            st_wr_parent = nr_reg;
            st_wr_size   = sum_reg;
            st_wr_weight = m_reg;
        end
    end

    atrm_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .ctl       (st_ctl),
        .rd_addr   (cur_reg),
        .wr_addr   (st_wr_addr),
        .wr_parent (st_wr_parent),
        .wr_size   (st_wr_size),
        .wr_weight (st_wr_weight),
        .rd_parent (rd_parent),
        .rd_size   (rd_size),
        .rd_weight (rd_weight)
    );

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAX_PIXELS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                if (!s_in_range)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CHK_A;
                end
            end
            S_CHK_A:
            begin
                if (rd_parent == cur_reg)
                begin
                    cur_next   = e_idx;
                    state_next = e_in_range ? S_RD_B : S_FINISH;
                end
                else
                begin
                    cur_next   = rd_parent;
                    state_next = S_RD_A;
                end
            end
            S_RD_B:
            begin
                state_next = S_CHK_B;
            end
            S_CHK_B:
            begin
                if (rd_parent == cur_reg)
                begin
                    state_next = (cur_reg == a_reg) ? S_FINISH : S_LIM_A;
                end
                else
                begin
                    cur_next   = rd_parent;
                    state_next = S_RD_B;
                end
            end
            S_LIM_A:  state_next = S_LIM_B;
            S_LIM_B:  state_next = S_LIM_C;
            S_LIM_C:  state_next = S_DECIDE;
            S_DECIDE: state_next = merge_ok ? S_WR_CHILD : S_FINISH;
            S_WR_CHILD: state_next = S_WR_ROOT;
            S_WR_ROOT:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
        if (accept)
        begin
            cur_next = s_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= K_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_wr_en)
            begin
                k_reg <= cfg_wr_data;
            end
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        cur_reg <= cur_next;
        if (state_reg == S_CHK_A && rd_parent == cur_reg)
        begin
            a_reg        <= cur_reg;
            sa_reg       <= rd_size;
            ia_reg       <= rd_weight;
            res_merged_reg <= 1'b0;
            res_root_reg <= 16'(cur_reg);
            res_size_reg <= rd_size;
        end
        if (state_reg == S_CHK_B && rd_parent == cur_reg)
        begin
            b_reg  <= cur_reg;
            sb_reg <= rd_size;
            ib_reg <= rd_weight;
        end
        if (state_reg == S_LIM_C)
        begin
            ok_a_reg <= lim_ok;
        end
        if (state_reg == S_DECIDE)
        begin
            sum_reg <= sum_sat;
            m_reg   <= m_all;
            if (b_wins)
            begin
                nr_reg         <= b_reg;
                child_reg      <= a_reg;
                child_size_reg <= sa_reg;
                child_wt_reg   <= ia_reg;
            end
            else
            begin
                nr_reg         <= a_reg;
                child_reg      <= b_reg;
                child_size_reg <= sb_reg;
                child_wt_reg   <= ib_reg;
            end
        end
        if (state_reg == S_WR_ROOT)
        begin
            res_merged_reg <= 1'b1;
            res_root_reg   <= nr_wide[15:0];
            res_size_reg   <= sum_reg;
        end
        if (state_reg == S_RD_A && !s_in_range)
        begin
            res_merged_reg <= 1'b0;
            res_root_reg   <= req_reg.edge_start;
            res_size_reg   <= SIZE_ONE;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            out_data_reg.merged      <= res_merged_reg;
            out_data_reg.result_root <= res_root_reg;
            out_data_reg.result_size <= res_size_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_ROOT) |-> (nr_reg != child_reg))
        else $error("merge of a component with itself");

    a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_merged_reg) |-> (res_size_reg >= SIZE_W'(2)))
        else $error("merged component smaller than two pixels");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        st_ctl.wr_en |-> !st_ctl.rd_en)
        else $error("store read and write in the same cycle");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> in_stall)
        else $error("second request taken while one is in work");

endmodule
